### rtl/minimal_set_family_insert_core_assert.svh
// assertion macros used by the checker file
`ifndef MINIMAL_SET_FAMILY_INSERT_CORE_ASSERT_SVH
`define MINIMAL_SET_FAMILY_INSERT_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MSFI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, disabled while in reset
`define MSFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/msfi_pkg.sv
// types, constants and codes of the minimal set family insert block
package msfi_pkg;

  localparam int ENTRIES  = 64;
  localparam int ELEMENTS = 32;
  localparam int MASK_W   = 32;
  localparam int IDX_W    = 6;
  localparam int STAT_W   = 3;
  localparam int AW       = $clog2(ENTRIES);
  localparam int CW       = $clog2(ENTRIES + 1);
  localparam int CMP_W    = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [MASK_W-1:0] ELEM_MASK  = MASK_W'((65'd1 << ELEMENTS) - 65'd1);
  localparam logic [CW-1:0]     FULL_COUNT = CW'(ENTRIES);

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_COVERED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_READ_OK  = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rd_entry;
    logic rd_scan;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic scan_end;
    logic out_free;
  } stat_t;

endpackage

### rtl/msfi_in_if.sv
// command channel interface
interface msfi_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [msfi_pkg::MASK_W-1:0]    set_mask;
  logic [msfi_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, cmd, set_mask, read_index, input ready);
  modport sink   (input valid, cmd, set_mask, read_index, output ready);
endinterface

### rtl/msfi_out_if.sv
// result channel interface
interface msfi_out_if;
  logic                           valid;
  logic                           ready;
  logic [msfi_pkg::STAT_W-1:0]    status;
  logic [msfi_pkg::MASK_W-1:0]    entry_mask;
  logic [msfi_pkg::CW-1:0]        family_count;

  modport source (output valid, status, entry_mask, family_count, input ready);
  modport sink   (input valid, status, entry_mask, family_count, output ready);
endinterface

### rtl/msfi_ctrl.sv
// sequencing state machine for reads and insert scans
module msfi_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  msfi_pkg::stat_t  stat,
  output msfi_pkg::ctrl_t  ctl
);

  msfi_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msfi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      msfi_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = msfi_pkg::S_DECODE;
        end
      end
      msfi_pkg::S_DECODE: begin
        if (stat.cmd == msfi_pkg::CMD_READ) begin
          ctl.rd_entry = 1'b1;
          state_nxt    = msfi_pkg::S_READ_WAIT;
        end else begin
          state_nxt = msfi_pkg::S_SCAN;
        end
      end
      msfi_pkg::S_READ_WAIT: begin
        state_nxt = msfi_pkg::S_DONE;
      end
      msfi_pkg::S_SCAN: begin
        // last read data is evaluated in the cycle that sees the end
        if (stat.scan_end) begin
          state_nxt = msfi_pkg::S_DONE;
        end else begin
          ctl.rd_scan = 1'b1;
        end
      end
      msfi_pkg::S_DONE: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = msfi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = msfi_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/msfi_dp.sv
// table memory, compare and compaction datapath, result register
module msfi_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msfi_pkg::ctrl_t               ctl,
  output msfi_pkg::stat_t               stat,
  input  logic                          in_cmd,
  input  logic [msfi_pkg::MASK_W-1:0]   in_set_mask,
  input  logic [msfi_pkg::IDX_W-1:0]    in_read_index,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [msfi_pkg::STAT_W-1:0]   out_status,
  output logic [msfi_pkg::MASK_W-1:0]   out_entry_mask,
  output logic [msfi_pkg::CW-1:0]       out_family_count
);

  logic [msfi_pkg::MASK_W-1:0] mem [msfi_pkg::ENTRIES];

  msfi_pkg::cmd_t               cmd_r;
  logic [msfi_pkg::MASK_W-1:0]  mask_r;
  logic [msfi_pkg::IDX_W-1:0]   idx_r;
  logic [msfi_pkg::CW-1:0]      count_r;
  logic [msfi_pkg::CW-1:0]      rptr_r;
  logic [msfi_pkg::CW-1:0]      kept_r;
  logic                         chk_r;
  logic                         covered_r;
  logic                         super_r;
  logic [msfi_pkg::MASK_W-1:0]  rd_data_r;
  logic                         out_valid_r;
  msfi_pkg::status_t            out_status_r;
  logic [msfi_pkg::MASK_W-1:0]  out_entry_r;
  logic [msfi_pkg::CW-1:0]      out_count_r;

  logic                         rd_en;
  logic [msfi_pkg::AW-1:0]      rd_addr;
  logic                         is_sub;
  logic                         is_strict_super;
  logic                         scan_wr;
  logic                         in_range;
  logic                         ins_ok;
  logic                         wr_en;
  logic [msfi_pkg::AW-1:0]      wr_addr;
  logic [msfi_pkg::MASK_W-1:0]  wr_data;
  msfi_pkg::status_t            status_nxt;
  logic [msfi_pkg::MASK_W-1:0]  entry_nxt;
  logic [msfi_pkg::CW-1:0]      count_nxt;

  assign rd_en   = ctl.rd_entry | ctl.rd_scan;
  assign rd_addr = ctl.rd_entry ? msfi_pkg::AW'(idx_r) : rptr_r[msfi_pkg::AW-1:0];

  // stored entry inside the mask covers it; strict superset is dropped
  assign is_sub          = (rd_data_r & ~mask_r) == '0;
  assign is_strict_super = ((mask_r & ~rd_data_r) == '0) && !is_sub;
  // survivors move down to the compaction pointer, which never passes the read pointer
  assign scan_wr         = chk_r && !is_strict_super;

  assign in_range = msfi_pkg::CMP_W'(idx_r) < msfi_pkg::CMP_W'(count_r);
  assign ins_ok   = !covered_r && (super_r || (count_r != msfi_pkg::FULL_COUNT));

  always_comb begin
    status_nxt = msfi_pkg::ST_INSERTED;
    entry_nxt  = '0;
    count_nxt  = count_r;
    if (cmd_r == msfi_pkg::CMD_READ) begin
      if (in_range) begin
        status_nxt = msfi_pkg::ST_READ_OK;
        entry_nxt  = rd_data_r;
      end else begin
        status_nxt = msfi_pkg::ST_RANGE;
      end
    end else if (covered_r) begin
      status_nxt = msfi_pkg::ST_COVERED;
    end else if (!ins_ok) begin
      status_nxt = msfi_pkg::ST_FULL;
    end else begin
      count_nxt = kept_r + msfi_pkg::CW'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = kept_r[msfi_pkg::AW-1:0];
    wr_data = rd_data_r;
    if (ctl.finish) begin
      wr_en   = (cmd_r == msfi_pkg::CMD_INSERT) && ins_ok;
      wr_data = mask_r;
    end else if (scan_wr) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= msfi_pkg::cmd_t'(in_cmd);
      mask_r <= in_set_mask & msfi_pkg::ELEM_MASK;
      idx_r  <= in_read_index;
    end
    if (ctl.finish) begin
      out_status_r <= status_nxt;
      out_entry_r  <= entry_nxt;
      out_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rptr_r      <= '0;
      kept_r      <= '0;
      chk_r       <= 1'b0;
      covered_r   <= 1'b0;
      super_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      chk_r <= ctl.rd_scan;
      if (ctl.capture) begin
        rptr_r    <= '0;
        kept_r    <= '0;
        covered_r <= 1'b0;
        super_r   <= 1'b0;
      end else begin
        if (ctl.rd_scan) begin
          rptr_r <= rptr_r + msfi_pkg::CW'(1);
        end
        if (chk_r) begin
          covered_r <= covered_r | is_sub;
          super_r   <= super_r | is_strict_super;
        end
        if (scan_wr) begin
          kept_r <= kept_r + msfi_pkg::CW'(1);
        end
      end
      if (ctl.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.scan_end = (rptr_r == count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_entry_mask   = out_entry_r;
  assign out_family_count = out_count_r;

endmodule

### rtl/minimal_set_family_insert_core.sv
// top level of the minimal set family insert block
//
// in_ch carries one command per transaction: an insert of set_mask
// (cmd 0) or a read of the table entry at read_index (cmd 1). out_ch
// returns exactly one result per command: status, entry_mask and the
// family count after the command.
// A read passes the decode, read-wait and done states. An insert scans
// every held entry once through the table's single read port, so its
// result time grows with the family count.
// Commands are handled one at a time; in_ch.ready is high again in the
// cycle after the result is loaded into the output register.
// The output register holds a finished result while out_ch.ready is
// low; the next command can be accepted and worked on meanwhile, and
// only its final step waits for the register to free.
// Synchronous active-low reset empties the family and drops any
// pending result; table contents are not cleared, only the count.
module minimal_set_family_insert_core (
  input  logic         clk,
  input  logic         rst_n,
  msfi_in_if.sink      in_ch,
  msfi_out_if.source   out_ch
);

  msfi_pkg::ctrl_t ctl;
  msfi_pkg::stat_t stat;

  msfi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  msfi_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_cmd           (in_ch.cmd),
    .in_set_mask      (in_ch.set_mask),
    .in_read_index    (in_ch.read_index),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_entry_mask   (out_ch.entry_mask),
    .out_family_count (out_ch.family_count)
  );

endmodule

### rtl/msfi_chk.sv
// port checker for the minimal set family insert block, with its bind
`include "minimal_set_family_insert_core_assert.svh"

module msfi_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [msfi_pkg::STAT_W-1:0]  out_status,
  input logic [msfi_pkg::MASK_W-1:0]  out_entry_mask,
  input logic [msfi_pkg::CW-1:0]      out_family_count
);

  logic                                                    out_stall;
  logic                                                    status_legal;
  logic                                                    is_read_ok;
  logic                                                    is_full;
  logic [msfi_pkg::STAT_W+msfi_pkg::MASK_W+msfi_pkg::CW-1:0] out_payload;

  assign out_stall    = out_valid && !out_ready;
  assign out_payload  = {out_status, out_entry_mask, out_family_count};
  assign status_legal = out_status inside {msfi_pkg::ST_INSERTED, msfi_pkg::ST_COVERED,
                                           msfi_pkg::ST_FULL, msfi_pkg::ST_READ_OK,
                                           msfi_pkg::ST_RANGE};
  assign is_read_ok   = (out_status == msfi_pkg::ST_READ_OK);
  assign is_full      = (out_status == msfi_pkg::ST_FULL);

  // a stalled result stays put
  `MSFI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_payload))

  `MSFI_ASSERT_IMPL(a_status_legal, clk, rst_n, out_valid, status_legal)

  // only a successful read carries a mask
  `MSFI_ASSERT_IMPL(a_entry_zero, clk, rst_n, out_valid && !is_read_ok, out_entry_mask == '0)

  `MSFI_ASSERT_IMPL(a_full_count, clk, rst_n, out_valid && is_full, out_family_count == msfi_pkg::FULL_COUNT)

endmodule

bind minimal_set_family_insert_core msfi_chk u_msfi_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_entry_mask   (out_ch.entry_mask),
  .out_family_count (out_ch.family_count)
);
